[sv/s16_pkg.sv]
// shared types and constants of the simple16 word unpacker
// layout selector codes, layout descriptor and the decode table; no dependencies
`default_nettype none

package s16_pkg;

  localparam int WORD_W    = 32;
  localparam int PAYLOAD_W = 28;
  localparam int SEL_W     = 4;
  localparam int FW_W      = 5;   // field width and field count
  localparam int POS_W     = 5;

  typedef enum logic [SEL_W-1:0] {
    SEL_28X1        = 4'd0,
    SEL_7X2_14X1    = 4'd1,
    SEL_7X1_7X2_7X1 = 4'd2,
    SEL_14X1_7X2    = 4'd3,
    SEL_14X2        = 4'd4,
    SEL_1X4_8X3     = 4'd5,
    SEL_1X3_4X4_3X3 = 4'd6,
    SEL_7X4         = 4'd7,
    SEL_4X5_2X4     = 4'd8,
    SEL_2X4_4X5     = 4'd9,
    SEL_3X6_2X5     = 4'd10,
    SEL_2X5_3X6     = 4'd11,
    SEL_4X7         = 4'd12,
    SEL_1X10_2X9    = 4'd13,
    SEL_2X14        = 4'd14,
    SEL_1X28        = 4'd15
  } sel_t;

  typedef struct packed {
    logic [1:0]      ngroups;
    logic [FW_W-1:0] cnt0;
    logic [FW_W-1:0] cnt1;
    logic [FW_W-1:0] cnt2;
    logic [FW_W-1:0] wid0;
    logic [FW_W-1:0] wid1;
    logic [FW_W-1:0] wid2;
  } layout_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    layout_t              lay;
  } entry_t;

  function automatic layout_t layout_of(input sel_t sel);
    layout_t l;
    unique case (sel)
      SEL_28X1:        l = '{2'd1, 5'd28, 5'd0,  5'd0, 5'd1,  5'd0, 5'd0};
      SEL_7X2_14X1:    l = '{2'd2, 5'd7,  5'd14, 5'd0, 5'd2,  5'd1, 5'd0};
      SEL_7X1_7X2_7X1: l = '{2'd3, 5'd7,  5'd7,  5'd7, 5'd1,  5'd2, 5'd1};
      SEL_14X1_7X2:    l = '{2'd2, 5'd14, 5'd7,  5'd0, 5'd1,  5'd2, 5'd0};
      SEL_14X2:        l = '{2'd1, 5'd14, 5'd0,  5'd0, 5'd2,  5'd0, 5'd0};
      SEL_1X4_8X3:     l = '{2'd2, 5'd1,  5'd8,  5'd0, 5'd4,  5'd3, 5'd0};
      SEL_1X3_4X4_3X3: l = '{2'd3, 5'd1,  5'd4,  5'd3, 5'd3,  5'd4, 5'd3};
      SEL_7X4:         l = '{2'd1, 5'd7,  5'd0,  5'd0, 5'd4,  5'd0, 5'd0};
      SEL_4X5_2X4:     l = '{2'd2, 5'd4,  5'd2,  5'd0, 5'd5,  5'd4, 5'd0};
      SEL_2X4_4X5:     l = '{2'd2, 5'd2,  5'd4,  5'd0, 5'd4,  5'd5, 5'd0};
      SEL_3X6_2X5:     l = '{2'd2, 5'd3,  5'd2,  5'd0, 5'd6,  5'd5, 5'd0};
      SEL_2X5_3X6:     l = '{2'd2, 5'd2,  5'd3,  5'd0, 5'd5,  5'd6, 5'd0};
      SEL_4X7:         l = '{2'd1, 5'd4,  5'd0,  5'd0, 5'd7,  5'd0, 5'd0};
      SEL_1X10_2X9:    l = '{2'd2, 5'd1,  5'd2,  5'd0, 5'd10, 5'd9, 5'd0};
      SEL_2X14:        l = '{2'd1, 5'd2,  5'd0,  5'd0, 5'd14, 5'd0, 5'd0};
      SEL_1X28:        l = '{2'd1, 5'd1,  5'd0,  5'd0, 5'd28, 5'd0, 5'd0};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

[sv/s16_front.sv]
// front stage: takes a codeword request and decodes its layout selector
// depends on s16_pkg
`default_nettype none

module s16_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [s16_pkg::WORD_W-1:0] in_codeword,
  output logic                            q_push,
  input  wire logic                       q_full,
  output s16_pkg::entry_t                 q_entry
);

  logic            valid_r, valid_nxt;
  s16_pkg::entry_t entry_r;
  logic            take;

  assign q_push  = valid_r;
  assign q_entry = entry_r;
  // stage frees up when its entry moves into the queue this cycle
  assign in_full = valid_r && q_full;
  assign take    = in_push && !in_full;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r.payload <= in_codeword[s16_pkg::PAYLOAD_W-1:0];
      entry_r.lay     <= s16_pkg::layout_of(
        s16_pkg::sel_t'(in_codeword[s16_pkg::WORD_W-1 -: s16_pkg::SEL_W]));
    end
  end

endmodule

`default_nettype wire

[sv/s16_queue.sv]
// short queue of decoded codewords between front and back
// depends on s16_pkg
`default_nettype none

module s16_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire s16_pkg::entry_t wr_entry,
  input  wire logic            pop,
  output logic                 valid,
  output s16_pkg::entry_t      rd_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  s16_pkg::entry_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign rd_entry = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

[sv/s16_back.sv]
// back stage: walks the fields of one decoded codeword, one value a cycle while the output register is free
// depends on s16_pkg
`default_nettype none

module s16_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire s16_pkg::entry_t               q_entry,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [s16_pkg::PAYLOAD_W-1:0]      out_value,
  output logic [s16_pkg::POS_W-1:0]          out_position,
  output logic                               out_last
);

  logic                            busy_r, busy_nxt;
  logic [s16_pkg::PAYLOAD_W-1:0]   sh_r;
  s16_pkg::layout_t                lay_r;
  logic [1:0]                      grp_r;
  logic [s16_pkg::FW_W-1:0]        k_r;
  logic [s16_pkg::POS_W-1:0]       pos_r;

  logic                            ov_r, ov_nxt;
  logic [s16_pkg::PAYLOAD_W-1:0]   val_r;
  logic [s16_pkg::POS_W-1:0]       opos_r;
  logic                            olast_r;

  logic [s16_pkg::FW_W-1:0]        cnt, wid;
  logic [s16_pkg::FW_W-1:0]        shamt;
  logic [s16_pkg::PAYLOAD_W-1:0]   field;
  logic                            slot_free, step, grp_done, is_last, load;

  always_comb begin
    unique case (grp_r)
      2'd0:    begin cnt = lay_r.cnt0; wid = lay_r.wid0; end
      2'd1:    begin cnt = lay_r.cnt1; wid = lay_r.wid1; end
      2'd2:    begin cnt = lay_r.cnt2; wid = lay_r.wid2; end
      default: begin cnt = '0;         wid = '0;         end
    endcase
  end

  // field sits at the top of the shift register
  assign shamt     = s16_pkg::FW_W'(s16_pkg::PAYLOAD_W) - wid;
  assign field     = sh_r >> shamt;
  assign slot_free = !ov_r || out_pop;
  assign step      = busy_r && slot_free;
  assign grp_done  = (k_r == cnt - s16_pkg::FW_W'(1));
  assign is_last   = grp_done && (grp_r == lay_r.ngroups - 2'd1);
  assign load      = q_valid && (!busy_r || (step && is_last));
  assign q_pop     = load;

  assign out_empty    = !ov_r;
  assign out_value    = val_r;
  assign out_position = opos_r;
  assign out_last     = olast_r;

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (step && is_last) begin
      busy_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (step) begin
      ov_nxt = 1'b1;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      grp_r  <= '0;
      k_r    <= '0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      if (load) begin
        grp_r <= '0;
        k_r   <= '0;
        pos_r <= '0;
      end else if (step) begin
        grp_r <= grp_done ? grp_r + 2'd1 : grp_r;
        k_r   <= grp_done ? '0 : k_r + s16_pkg::FW_W'(1);
        pos_r <= pos_r + s16_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r  <= q_entry.payload;
      lay_r <= q_entry.lay;
    end else if (step) begin
      sh_r  <= sh_r << wid;
    end
    if (step) begin
      val_r   <= field;
      opos_r  <= pos_r;
      olast_r <= is_last;
    end
  end

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && !is_last |=> busy_r && (pos_r == $past(pos_r) + s16_pkg::POS_W'(1)))
    else $error("field position did not advance within a codeword");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && pos_r == '0 && grp_r == 2'd0 && k_r == '0)
    else $error("walk counters not cleared on codeword load");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> ov_r)
    else $error("emitted field did not reach the output register");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_pop |=> ov_r && $stable(val_r) && $stable(opos_r) && $stable(olast_r))
    else $error("waiting result changed before it was taken");

  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !(step && is_last) |-> !load)
    else $error("new codeword loaded while fields remain");

endmodule

`default_nettype wire

[sv/simple16_word_unpacker.sv]
// top level of the simple16 word unpacker: front decode, queue, field walker
// depends on s16_pkg, s16_front, s16_queue, s16_back
//
// usage
//   input channel: a 32-bit codeword request is taken on a rising edge with
//   in_push high and in_full low; bits 31..28 pick one of sixteen layouts,
//   bits 27..0 hold the fields, most significant field first
//   result channel: while out_empty is low, out_value / out_position /
//   out_last show the oldest waiting value; it is taken on an edge with
//   out_pop high; out_last marks the final field of a codeword
// path: the first value of a codeword passes the front register, the queue,
//   the field walker and the output register before it shows
// throughput: the field walker emits one value a cycle while results are taken;
//   a codeword has 1 to 28 fields, and when the queue holds the next codeword
//   its walk follows the last field of the previous one without a pause
// stalls: a held result freezes the walker; the queue and front register
//   keep taking requests until they fill, then in_full rises
// reset: synchronous, active low; clears all valid flags and pointers,
//   nothing is left in flight
`default_nettype none

module simple16_word_unpacker #(
  parameter int QUEUE_DEPTH = 2   // decoded codewords between front and back, 2 or more
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // codeword requests
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [s16_pkg::WORD_W-1:0]    in_codeword,
  // unpacked values
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [s16_pkg::PAYLOAD_W-1:0]      out_value,
  output logic [s16_pkg::POS_W-1:0]          out_position,
  output logic                               out_last
);

  // front to queue
  logic            fq_push, fq_full;
  s16_pkg::entry_t fq_entry;
  // queue to back
  logic            qb_valid, qb_pop;
  s16_pkg::entry_t qb_entry;

  // register stage that decodes the selector into a layout descriptor
  s16_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_codeword (in_codeword),
    .q_push      (fq_push),
    .q_full      (fq_full),
    .q_entry     (fq_entry)
  );

  // decouples request intake from the field walk
  s16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .full     (fq_full),
    .wr_entry (fq_entry),
    .pop      (qb_pop),
    .valid    (qb_valid),
    .rd_entry (qb_entry)
  );

  // walks fields one per cycle into the output register while that register is free
  s16_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (qb_valid),
    .q_pop        (qb_pop),
    .q_entry      (qb_entry),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_value    (out_value),
    .out_position (out_position),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

[tb/s16_unpack_check.sv]
// checker for the simple16 word unpacker: watches both channels, predicts the
// unpacked fields of each codeword request and compares them in order
// depends on s16_pkg (widths and layout selector codes)

module s16_unpack_check (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire logic                          in_full,
  input  wire logic [s16_pkg::WORD_W-1:0]    in_codeword,
  input  wire logic                          out_empty,
  input  wire logic                          out_pop,
  input  wire logic [s16_pkg::PAYLOAD_W-1:0] out_value,
  input  wire logic [s16_pkg::POS_W-1:0]     out_position,
  input  wire logic                          out_last,
  output logic [31:0]                        mismatches,
  output logic [31:0]                        fields_due,
  output logic [31:0]                        codewords_seen,
  output logic [31:0]                        fields_checked
);

  typedef struct {
    logic [s16_pkg::PAYLOAD_W-1:0] value;
    logic [s16_pkg::POS_W-1:0]     position;
    logic                          last;
  } field_t;

  field_t pending_fields[$];
  int     lines_printed = 0;

  initial begin
    mismatches     = '0;
    fields_due     = '0;
    codewords_seen = '0;
    fields_checked = '0;
  end

  task automatic report_mismatch(input string what);
    if (lines_printed < 60) $display("mismatch: %s", what);
    lines_printed++;
    mismatches = mismatches + 1;
  endtask

  // cut the payload into fields, msb first, and queue one expectation per field
  function automatic void unpack_codeword(input logic [s16_pkg::WORD_W-1:0] cw);
    s16_pkg::sel_t                 sel;
    logic [s16_pkg::PAYLOAD_W-1:0] payload;
    int                            cnt[3];
    int                            wid[3];
    int                            used;
    int                            n;
    logic [31:0]                   mask;
    field_t                        f;
    sel     = s16_pkg::sel_t'(cw[s16_pkg::WORD_W-1 -: s16_pkg::SEL_W]);
    payload = cw[s16_pkg::PAYLOAD_W-1:0];
    cnt = '{0, 0, 0};
    wid = '{0, 0, 0};
    case (sel)
      s16_pkg::SEL_28X1:        begin cnt = '{28, 0, 0};  wid = '{1, 0, 0};  end
      s16_pkg::SEL_7X2_14X1:    begin cnt = '{7, 14, 0};  wid = '{2, 1, 0};  end
      s16_pkg::SEL_7X1_7X2_7X1: begin cnt = '{7, 7, 7};   wid = '{1, 2, 1};  end
      s16_pkg::SEL_14X1_7X2:    begin cnt = '{14, 7, 0};  wid = '{1, 2, 0};  end
      s16_pkg::SEL_14X2:        begin cnt = '{14, 0, 0};  wid = '{2, 0, 0};  end
      s16_pkg::SEL_1X4_8X3:     begin cnt = '{1, 8, 0};   wid = '{4, 3, 0};  end
      s16_pkg::SEL_1X3_4X4_3X3: begin cnt = '{1, 4, 3};   wid = '{3, 4, 3};  end
      s16_pkg::SEL_7X4:         begin cnt = '{7, 0, 0};   wid = '{4, 0, 0};  end
      s16_pkg::SEL_4X5_2X4:     begin cnt = '{4, 2, 0};   wid = '{5, 4, 0};  end
      s16_pkg::SEL_2X4_4X5:     begin cnt = '{2, 4, 0};   wid = '{4, 5, 0};  end
      s16_pkg::SEL_3X6_2X5:     begin cnt = '{3, 2, 0};   wid = '{6, 5, 0};  end
      s16_pkg::SEL_2X5_3X6:     begin cnt = '{2, 3, 0};   wid = '{5, 6, 0};  end
      s16_pkg::SEL_4X7:         begin cnt = '{4, 0, 0};   wid = '{7, 0, 0};  end
      s16_pkg::SEL_1X10_2X9:    begin cnt = '{1, 2, 0};   wid = '{10, 9, 0}; end
      s16_pkg::SEL_2X14:        begin cnt = '{2, 0, 0};   wid = '{14, 0, 0}; end
      s16_pkg::SEL_1X28:        begin cnt = '{1, 0, 0};   wid = '{28, 0, 0}; end
      default:                  begin cnt = '{0, 0, 0};   wid = '{0, 0, 0};  end
    endcase
    used = 0;
    n    = 0;
    for (int g = 0; g < 3; g++) begin
      for (int k = 0; k < cnt[g]; k++) begin
        mask       = (32'd1 << wid[g]) - 32'd1;
        f.value    = s16_pkg::PAYLOAD_W'((32'(payload) >>
                       (s16_pkg::PAYLOAD_W - used - wid[g])) & mask);
        f.position = s16_pkg::POS_W'(n);
        f.last     = 1'b0;
        pending_fields.push_back(f);
        used += wid[g];
        n++;
      end
    end
    if (n > 0) pending_fields[pending_fields.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    field_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_fields.size() == 0) begin
          report_mismatch($sformatf("value %0h pos %0d with nothing expected",
                                    out_value, out_position));
        end else begin
          want = pending_fields.pop_front();
          if (out_value !== want.value)
            report_mismatch($sformatf("pos %0d value %0h, want %0h",
                                      want.position, out_value, want.value));
          if (out_position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      out_position, want.position));
          if (out_last !== want.last)
            report_mismatch($sformatf("pos %0d last %b, want %b",
                                      want.position, out_last, want.last));
        end
        fields_checked <= fields_checked + 1;
      end
      if (in_push && !in_full) begin
        unpack_codeword(in_codeword);
        codewords_seen <= codewords_seen + 1;
      end
    end
    fields_due <= pending_fields.size();
  end

  final begin
    if (pending_fields.size() != 0)
      $display("note: %0d fields still expected at close", pending_fields.size());
  end

endmodule

[tb/testbench.sv]
// top of the simple16 word unpacker bench: clock, reset, codeword requests,
// result pops and the verdict; depends on s16_pkg, s16_unpack_check and the block

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 160;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_push      = 1'b0;
  logic [s16_pkg::WORD_W-1:0]    in_codeword  = '0;
  logic                          out_pop      = 1'b0;
  logic                          steady       = 1'b0;   // both sides busy every cycle
  logic                          in_full;
  logic                          out_empty;
  logic [s16_pkg::PAYLOAD_W-1:0] out_value;
  logic [s16_pkg::POS_W-1:0]     out_position;
  logic                          out_last;
  logic [31:0]                   mismatches;
  logic [31:0]                   fields_due;
  logic [31:0]                   codewords_seen;
  logic [31:0]                   fields_checked;
  int                            cycles = 0;

  // 20 unit period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  simple16_word_unpacker dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_codeword  (in_codeword),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_value    (out_value),
    .out_position (out_position),
    .out_last     (out_last)
  );

  s16_unpack_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_codeword    (in_codeword),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_value      (out_value),
    .out_position   (out_position),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .fields_due     (fields_due),
    .codewords_seen (codewords_seen),
    .fields_checked (fields_checked)
  );

  // guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simple16_word_unpacker verification failed");
      $finish;
    end
  end

  // result side: pops at random about 69 times in a hundred, and always while steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (steady) begin
      out_pop <= 1'b1;
    end else begin
      out_pop <= ($urandom_range(99) >= 31);
    end
  end

  // one codeword request: hold push until taken, then maybe idle a while;
  // push stays high into the next request when no idle cycle follows
  task automatic push_codeword(input logic [s16_pkg::WORD_W-1:0] cw);
    in_push     <= 1'b1;
    in_codeword <= cw;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // random selector; payload mostly random, sometimes all ones, zero or one hot
  function automatic logic [s16_pkg::WORD_W-1:0] random_codeword();
    logic [s16_pkg::SEL_W-1:0]     sel;
    logic [s16_pkg::PAYLOAD_W-1:0] payload;
    sel     = s16_pkg::SEL_W'($urandom_range(15));
    payload = s16_pkg::PAYLOAD_W'($urandom);
    case ($urandom_range(9))
      0:       payload = '1;
      1:       payload = '0;
      2:       payload = s16_pkg::PAYLOAD_W'(1) << $urandom_range(s16_pkg::PAYLOAD_W-1);
      default: ;
    endcase
    return {sel, payload};
  endfunction

  initial begin
    logic [s16_pkg::WORD_W-1:0] directed[$];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every layout with every field at its maximum
    for (int s = 0; s < 16; s++)
      directed.push_back({s16_pkg::SEL_W'(s), {s16_pkg::PAYLOAD_W{1'b1}}});
    // all-zero word, alternating bit patterns across narrow and wide layouts,
    // a lone low payload bit in the single wide field, a lone high bit in 4x5+2x4
    directed.push_back('0);
    directed.push_back({s16_pkg::SEL_7X2_14X1, 28'h5555555});
    directed.push_back({s16_pkg::SEL_7X1_7X2_7X1, 28'hAAAAAAA});
    directed.push_back({s16_pkg::SEL_1X10_2X9, 28'h5555555});
    directed.push_back({s16_pkg::SEL_2X14, 28'hAAAAAAA});
    directed.push_back({s16_pkg::SEL_1X28, 28'h0000001});
    directed.push_back({s16_pkg::SEL_4X5_2X4, 28'h8000000});
    foreach (directed[i]) push_codeword(directed[i]);

    // random requests; a stretch in the middle runs with no idling at all
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 60) steady <= 1'b1;
      if (i == 100) steady <= 1'b0;
      push_codeword(random_codeword());
    end
    in_push <= 1'b0;

    // drain, then wait for anything stray to show
    @(posedge clk);
    while (fields_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d codewords over all sixteen layouts, %0d unpacked values checked",
             codewords_seen, fields_checked);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("simple16_word_unpacker verification clean");
    end else begin
      $display("simple16_word_unpacker verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/s16_pkg.sv
sv/s16_front.sv
sv/s16_queue.sv
sv/s16_back.sv
sv/simple16_word_unpacker.sv
tb/s16_unpack_check.sv
tb/testbench.sv
